/* src/ced_pkg.sv */
// ----------------------------------------------------------------------------
// ced_pkg
// Types, character constants and helper functions for the content string
// escape decoder.
// ----------------------------------------------------------------------------
package ced_pkg;

  localparam int unsigned MaxResults = 5;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  typedef logic [7:0]      char_t;
  typedef logic [CntW-1:0] cnt_t;

  localparam logic MODE_BYTE  = 1'b0;
  localparam logic MODE_REGEX = 1'b1;

  localparam char_t CHAR_BSLASH = 8'h5C;
  localparam char_t CHAR_PIPE   = 8'h7C;
  localparam char_t CHAR_X      = 8'h78;
  localparam char_t CHAR_NUL    = 8'h00;
  localparam char_t CHAR_SPACE  = 8'h20;
  localparam char_t CHAR_TAB    = 8'h09;

  function automatic logic [3:0] nibble_of(input char_t c);
    logic [3:0] r;
    r = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = 4'(c - 8'h61 + 8'd10);
    end
    return r;
  endfunction

  function automatic logic is_meta(input char_t c);
    logic r;
    case (c)
      8'h2E, 8'h5C, 8'h2A, 8'h2B, 8'h3F, 8'h28, 8'h29, 8'h5B,
      8'h5D, 8'h7B, 8'h7D, 8'h2C, 8'h5E, 8'h7C, 8'h2D: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* src/ced_in_if.sv */
// ----------------------------------------------------------------------------
// ced_in_if
// Character input channel: valid, ready and one character with its end flag.
// ----------------------------------------------------------------------------
interface ced_in_if
  import ced_pkg::*;
  ();
  logic  valid;
  logic  ready;
  char_t in_char;
  logic  in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

/* src/ced_out_if.sv */
// ----------------------------------------------------------------------------
// ced_out_if
// Byte output channel: valid, ready and one output byte with its end flag.
// ----------------------------------------------------------------------------
interface ced_out_if
  import ced_pkg::*;
  ();
  logic  valid;
  logic  ready;
  char_t out_byte;
  logic  out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

/* src/content_escape_decoder_top.sv */
// ----------------------------------------------------------------------------
// content_escape_decoder_top
// Decodes content string characters into raw bytes or regex-escaped text.
//
//   channel   direction  payload             transfer when
//   in_chan   sink       in_char, in_last    valid & ready
//   out_chan  source     out_byte, out_last  valid & ready
//   cfg       write      cfg_wdata (mode)    cfg_we
//
// A character is decoded in the cycle it transfers into a result buffer of
// up to five bytes, which drains one byte per cycle while out_chan is ready.
// A new character is taken when the buffer is empty or its final byte
// transfers in the same cycle, so items with at most one result run at one
// per cycle while the output is not stalled. Reset empties the buffer and
// clears the decode state and the mode. A stalled output holds its byte.
// ----------------------------------------------------------------------------
module content_escape_decoder_top
  import ced_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ced_in_if.sink      in_chan,
  ced_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  logic  mode_r;
  logic  hex_r, hex_nxt;
  logic  esc_r, esc_nxt;
  logic  held_r, held_nxt;
  char_t hchar_r, hchar_nxt;

  char_t buf_r [MaxResults];
  cnt_t  cnt_r;
  logic  last_r;

  char_t lst [MaxResults];
  cnt_t  n;
  logic  in_xfer, out_xfer, regex;
  char_t c;

  assign c        = in_chan.in_char;
  assign regex    = (mode_r == MODE_REGEX);
  assign out_xfer = out_chan.valid && out_chan.ready;
  assign in_chan.ready = (cnt_r == '0) || ((cnt_r == cnt_t'(1)) && out_chan.ready);
  assign in_xfer  = in_chan.valid && in_chan.ready;

  assign out_chan.valid    = (cnt_r != '0);
  assign out_chan.out_byte = buf_r[0];
  assign out_chan.out_last = last_r && (cnt_r == cnt_t'(1));

  always_comb begin
    for (int i = 0; i < MaxResults; i++) begin
      lst[i] = CHAR_NUL;
    end
    n         = '0;
    hex_nxt   = hex_r;
    esc_nxt   = esc_r;
    held_nxt  = held_r;
    hchar_nxt = hchar_r;
    if (esc_r) begin
      lst[n] = c;
      n = n + cnt_t'(1);
      esc_nxt = 1'b0;
    end else if (hex_r) begin
      if (c == CHAR_PIPE) begin
        hex_nxt  = 1'b0;
        held_nxt = 1'b0;
      end else if (c == CHAR_SPACE || c == CHAR_TAB) begin
        held_nxt = held_r;
      end else if (!held_r) begin
        hchar_nxt = c;
        held_nxt  = 1'b1;
      end else begin
        if (regex) begin
          lst[0] = CHAR_BSLASH;
          lst[1] = CHAR_X;
          lst[2] = hchar_r;
          lst[3] = c;
          n = cnt_t'(4);
        end else begin
          lst[0] = {nibble_of(hchar_r), nibble_of(c)};
          n = cnt_t'(1);
        end
        held_nxt = 1'b0;
      end
    end else if (c == CHAR_BSLASH) begin
      if (regex) begin
        lst[0] = CHAR_BSLASH;
        n = cnt_t'(1);
      end
      esc_nxt = 1'b1;
    end else if (c == CHAR_PIPE) begin
      hex_nxt  = 1'b1;
      held_nxt = 1'b0;
    end else begin
      if (regex && is_meta(c)) begin
        lst[n] = CHAR_BSLASH;
        n = n + cnt_t'(1);
      end
      lst[n] = c;
      n = n + cnt_t'(1);
    end
    if (in_chan.in_last) begin
      if (regex) begin
        lst[n] = CHAR_NUL;
        n = n + cnt_t'(1);
      end
      hex_nxt   = 1'b0;
      esc_nxt   = 1'b0;
      held_nxt  = 1'b0;
      hchar_nxt = CHAR_NUL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_BYTE;
      hex_r   <= 1'b0;
      esc_r   <= 1'b0;
      held_r  <= 1'b0;
      hchar_r <= CHAR_NUL;
      cnt_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (in_xfer) begin
        hex_r   <= hex_nxt;
        esc_r   <= esc_nxt;
        held_r  <= held_nxt;
        hchar_r <= hchar_nxt;
        cnt_r   <= n;
        last_r  <= in_chan.in_last;
      end else if (out_xfer) begin
        cnt_r <= cnt_r - cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < MaxResults; i++) begin
        buf_r[i] <= lst[i];
      end
    end else if (out_xfer) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
      buf_r[MaxResults-1] <= CHAR_NUL;
    end
  end

endmodule

/* src/ced_checker.sv */
// ----------------------------------------------------------------------------
// ced_checker
// Port-level assertions for the content string escape decoder.
// ----------------------------------------------------------------------------
module ced_checker
  import ced_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input char_t out_byte,
  input logic  out_last
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready while no result is pending");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input ready while a result is stalled");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output valid dropped without a transfer");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_byte) && $stable(out_last)))
    else $error("stalled output payload changed");

endmodule

bind content_escape_decoder_top ced_checker u_ced_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_byte  (out_chan.out_byte),
  .out_last  (out_chan.out_last)
);
